// ===== rtl/qte_pkg.sv =====
`default_nettype none
package qte_pkg;

    // Default CORDIC depth and the fixed component format (Q2.14).
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COMPONENT_BITS = 16;

    // Working formats: sums with 28 fraction bits, CORDIC vectors, angles.
    localparam int SUM_W = 34;
    localparam int SPC_W = 29;
    localparam int XW = 38;
    localparam int ZW = 29;
    localparam int ROOT_W = 29;
    localparam int REM_W = 32;
    localparam int RAD_W = 58;
    localparam int SQRT_CELLS = RAD_W / 2;

    localparam logic signed [ZW-1:0] ANG_PI = ZW'(52707179);
    localparam logic signed [15:0] OUT_PI = 16'sd25736;
    localparam logic signed [15:0] OUT_HALF_PI = 16'sd12868;
    localparam logic [RAD_W-1:0] RAD_ONE = RAD_W'(1) << 56;

    // Everything the front end hands on to the CORDIC lanes.
    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [SPC_W-1:0] spc;
        logic                    clamp;
        logic                    neg;
    } carry_t;

    // State of the digit-by-digit square root.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } sqrt_t;

    // State of one vectoring CORDIC lane.
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    // Arctangent of 2^-i with 24 fraction bits.
    function automatic logic signed [ZW-1:0] step_angle(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0: a = ZW'(13176795);
            1: a = ZW'(7778716);
            2: a = ZW'(4110060);
            3: a = ZW'(2086331);
            4: a = ZW'(1047214);
            5: a = ZW'(524117);
            6: a = ZW'(262123);
            7: a = ZW'(131069);
            8: a = ZW'(65536);
            default: begin
                if (i <= 24) begin
                    a = ZW'(1) << (24 - i);
                end else begin
                    a = '0;
                end
            end
        endcase
        return a;
    endfunction

    // Turn a vector in the left half plane by pi before the CORDIC runs.
    function automatic cordic_t pre_rotate(input logic signed [XW-1:0] y,
                                           input logic signed [XW-1:0] x);
        cordic_t c;
        c.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            c.z = (y >= 0) ? ANG_PI : -ANG_PI;
            c.x = -x;
            c.y = -y;
        end else begin
            c.z = '0;
            c.x = x;
            c.y = y;
        end
        return c;
    endfunction

    // Round an angle to Q3.13 and saturate to plus or minus pi.
    function automatic logic [15:0] to_out(input cordic_t c);
        logic signed [ZW-1:0]  t;
        logic signed [ZW-12:0] r;
        logic signed [15:0]    o;
        t = (c.zero ? ZW'(0) : c.z) + ZW'(1024);
        r = t[ZW-1:11];
        if (r > (ZW-11)'(OUT_PI)) begin
            o = OUT_PI;
        end else if (r < -(ZW-11)'(OUT_PI)) begin
            o = -OUT_PI;
        end else begin
            o = r[15:0];
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qte_sqrt_cell.sv =====
`default_nettype none
module qte_sqrt_cell (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire qte_pkg::sqrt_t  st_in,
    input  wire qte_pkg::carry_t cy_in,
    output qte_pkg::sqrt_t       st_out,
    output qte_pkg::carry_t      cy_out
);
    import qte_pkg::*;

    sqrt_t            st_reg;
    carry_t           cy_reg;
    sqrt_t            st_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // One root bit per cell: bring down two radicand bits and try a subtract.
    always_comb begin
        rem_sh = {st_in.rem[REM_W-3:0], st_in.rad[RAD_W-1 -: 2]};
        trial = {1'b0, st_in.root, 2'b01};
        ge = (rem_sh >= trial);
        st_next.rem = ge ? (rem_sh - trial) : rem_sh;
        st_next.root = {st_in.root[ROOT_W-2:0], ge};
        st_next.rad = {st_in.rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
            cy_reg <= cy_in;
        end
    end

    assign st_out = st_reg;
    assign cy_out = cy_reg;
endmodule
`default_nettype wire

// ===== rtl/qte_cordic_cell.sv =====
`default_nettype none
module qte_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire qte_pkg::cordic_t c_in,
    output qte_pkg::cordic_t      c_out
);
    import qte_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE = step_angle(SHIFT);

    cordic_t              c_reg;
    cordic_t              c_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    // One vectoring micro-rotation that drives y toward zero.
    always_comb begin
        xs = c_in.x >>> SHIFT;
        ys = c_in.y >>> SHIFT;
        c_next.zero = c_in.zero;
        if (c_in.y >= 0) begin
            c_next.x = c_in.x + ys;
            c_next.y = c_in.y - xs;
            c_next.z = c_in.z + ANGLE;
        end else begin
            c_next.x = c_in.x - ys;
            c_next.y = c_in.y + xs;
            c_next.z = c_in.z - ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;
endmodule
`default_nettype wire

// ===== rtl/quaternion_to_euler.sv =====
// Throughput: one quaternion per cycle while s_tready is high; the root stage is a
// chain of 29 cells, one root bit each, followed by three lanes of CORDIC_STEPS
// rotation cells. An output register with a skid stage keeps input flowing while a
// result waits; s_tready drops while the skid stage holds a result.
// Reset (aresetn low, synchronous) clears all valid flags; data is not cleared.
`default_nettype none
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // angle_about_y, angle_about_z, angle_about_x
    output logic [0:0]       m_tuser    // pitch_clamped
);
    import qte_pkg::*;

    localparam int PIPE = 4 + SQRT_CELLS + CORDIC_STEPS;

    logic en;
    logic accept;
    logic [PIPE-1:0] v_reg;
    logic [PIPE-1:0] v_next;

    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wz_reg;
    logic signed [31:0] p_xy_reg, p_zz_reg, p_wy_reg, p_zx_reg;

    carry_t c2_reg, c2_next;
    carry_t c3_reg;
    logic [RAD_W-1:0] sq_reg;
    logic signed [RAD_W-1:0] sq_full;
    logic signed [SUM_W-1:0] sp;

    sqrt_t  sq_st [0:SQRT_CELLS];
    carry_t sq_cy [0:SQRT_CELLS];

    cordic_t ch_p [0:CORDIC_STEPS];
    cordic_t ch_y [0:CORDIC_STEPS];
    cordic_t ch_r [0:CORDIC_STEPS];
    logic [1:0] cl_reg [0:CORDIC_STEPS];

    logic [47:0] res_data;
    logic [47:0] out_data_reg, skid_data_reg;
    logic        out_user_reg, skid_user_reg;
    logic        out_valid_reg, skid_valid_reg;

    assign en = !skid_valid_reg;
    assign accept = s_tvalid && en;
    assign s_tready = en;

    // Valid flags move along with the data.
    assign v_next = {v_reg[PIPE-2:0], accept};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    // Stage one: the nine products, each with 28 fraction bits.
    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];
    always_ff @(posedge aclk) begin
        if (en) begin
            p_wx_reg <= qw * qx;
            p_yz_reg <= qy * qz;
            p_xx_reg <= qx * qx;
            p_yy_reg <= qy * qy;
            p_wz_reg <= qw * qz;
            p_xy_reg <= qx * qy;
            p_zz_reg <= qz * qz;
            p_wy_reg <= qw * qy;
            p_zx_reg <= qz * qx;
        end
    end

    // Stage two: sine and cosine terms and the pitch clamp test.
    always_comb begin
        sp = (SUM_W'(p_wy_reg) - SUM_W'(p_zx_reg)) <<< 1;
        c2_next.sr = (SUM_W'(p_wx_reg) + SUM_W'(p_yz_reg)) <<< 1;
        c2_next.cr = (SUM_W'(1) <<< 28) - ((SUM_W'(p_xx_reg) + SUM_W'(p_yy_reg)) <<< 1);
        c2_next.sy = (SUM_W'(p_wz_reg) + SUM_W'(p_xy_reg)) <<< 1;
        c2_next.cy = (SUM_W'(1) <<< 28) - ((SUM_W'(p_yy_reg) + SUM_W'(p_zz_reg)) <<< 1);
        c2_next.clamp = (sp >= (SUM_W'(1) <<< 28)) || (sp <= -(SUM_W'(1) <<< 28));
        c2_next.neg = sp[SUM_W-1];
        c2_next.spc = c2_next.clamp ? '0 : sp[SPC_W-1:0];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg <= c2_next;
        end
    end

    // Stage three: the square of the pitch sine, kept at full width.
    assign sq_full = RAD_W'(c2_reg.spc) * RAD_W'(c2_reg.spc);
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= unsigned'(sq_full);
            c3_reg <= c2_reg;
        end
    end

    // Square root chain for the pitch cosine.
    assign sq_st[0].rem = '0;
    assign sq_st[0].root = '0;
    assign sq_st[0].rad = RAD_ONE - sq_reg;
    assign sq_cy[0] = c3_reg;

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .aclk   (aclk),
            .en     (en),
            .st_in  (sq_st[k]),
            .cy_in  (sq_cy[k]),
            .st_out (sq_st[k+1]),
            .cy_out (sq_cy[k+1])
        );
    end

    // Quadrant correction at the head of the three CORDIC lanes.
    always_ff @(posedge aclk) begin
        if (en) begin
            ch_p[0] <= pre_rotate(XW'(sq_cy[SQRT_CELLS].spc),
                                  signed'(XW'(sq_st[SQRT_CELLS].root)));
            ch_y[0] <= pre_rotate(XW'(sq_cy[SQRT_CELLS].sy), XW'(sq_cy[SQRT_CELLS].cy));
            ch_r[0] <= pre_rotate(XW'(sq_cy[SQRT_CELLS].sr), XW'(sq_cy[SQRT_CELLS].cr));
            cl_reg[0] <= {sq_cy[SQRT_CELLS].clamp, sq_cy[SQRT_CELLS].neg};
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        qte_cordic_cell #(.SHIFT(k)) u_pitch (
            .aclk (aclk), .en (en), .c_in (ch_p[k]), .c_out (ch_p[k+1])
        );
        qte_cordic_cell #(.SHIFT(k)) u_yaw (
            .aclk (aclk), .en (en), .c_in (ch_y[k]), .c_out (ch_y[k+1])
        );
        qte_cordic_cell #(.SHIFT(k)) u_roll (
            .aclk (aclk), .en (en), .c_in (ch_r[k]), .c_out (ch_r[k+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                cl_reg[k+1] <= cl_reg[k];
            end
        end
    end

    // Rounding, saturation and the pitch clamp.
    always_comb begin
        res_data[47:32] = to_out(ch_r[CORDIC_STEPS]);
        res_data[31:16] = to_out(ch_y[CORDIC_STEPS]);
        if (cl_reg[CORDIC_STEPS][1]) begin
            res_data[15:0] = cl_reg[CORDIC_STEPS][0] ? -OUT_HALF_PI : OUT_HALF_PI;
        end else begin
            res_data[15:0] = to_out(ch_p[CORDIC_STEPS]);
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= v_reg[PIPE-1];
            end else begin
                skid_valid_reg <= v_reg[PIPE-1];
            end
        end else if (m_tready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= res_data;
                out_user_reg <= cl_reg[CORDIC_STEPS][1];
            end else begin
                skid_data_reg <= res_data;
                skid_user_reg <= cl_reg[CORDIC_STEPS][1];
            end
        end else if (m_tready) begin
            out_data_reg <= skid_data_reg;
            out_user_reg <= skid_user_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

    // A filled skid stage always sits behind a valid output beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full without an output beat");

    // An accepted beat enters the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted beat lost at pipeline entry");

    // A clamped pitch is exactly plus or minus pi/2.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[15:0] == OUT_HALF_PI || m_tdata[15:0] == -OUT_HALF_PI))
        else $error("clamped pitch has wrong value");

    // Roll stays within plus or minus pi.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[47:32]) <= OUT_PI && $signed(m_tdata[47:32]) >= -OUT_PI))
        else $error("roll out of range");
endmodule
`default_nettype wire
